>>> hdl/rmd_pkg.sv
// Shared types, constants and round functions for the RIPEMD hash engine.
// No dependencies; used by every module under hdl except rmd_checker.
package rmd_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } rmd_item_t;

  localparam logic [1:0] VAR_128 = 2'd0;
  localparam logic [1:0] VAR_160 = 2'd1;
  localparam logic [1:0] VAR_256 = 2'd2;
  localparam logic [1:0] VAR_320 = 2'd3;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;
  localparam logic [5:0] BLK_END  = 6'd63;

  localparam logic [31:0] KL [5] = '{32'h00000000, 32'h5a827999, 32'h6ed9eba1,
                                     32'h8f1bbcdc, 32'ha953fd4e};
  localparam logic [31:0] KR5 [5] = '{32'h50a28be6, 32'h5c4dd124, 32'h6d703ef3,
                                      32'h7a6d76e9, 32'h00000000};
  localparam logic [31:0] KR4 [5] = '{32'h50a28be6, 32'h5c4dd124, 32'h6d703ef3,
                                      32'h00000000, 32'h00000000};

  localparam logic [3:0] MSG_L [80] = '{
    4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13,
    4'd14, 4'd15,
    4'd7, 4'd4, 4'd13, 4'd1, 4'd10, 4'd6, 4'd15, 4'd3, 4'd12, 4'd0, 4'd9, 4'd5, 4'd2, 4'd14,
    4'd11, 4'd8,
    4'd3, 4'd10, 4'd14, 4'd4, 4'd9, 4'd15, 4'd8, 4'd1, 4'd2, 4'd7, 4'd0, 4'd6, 4'd13, 4'd11,
    4'd5, 4'd12,
    4'd1, 4'd9, 4'd11, 4'd10, 4'd0, 4'd8, 4'd12, 4'd4, 4'd13, 4'd3, 4'd7, 4'd15, 4'd14, 4'd5,
    4'd6, 4'd2,
    4'd4, 4'd0, 4'd5, 4'd9, 4'd7, 4'd12, 4'd2, 4'd10, 4'd14, 4'd1, 4'd3, 4'd8, 4'd11, 4'd6,
    4'd15, 4'd13};
  localparam logic [3:0] MSG_R [80] = '{
    4'd5, 4'd14, 4'd7, 4'd0, 4'd9, 4'd2, 4'd11, 4'd4, 4'd13, 4'd6, 4'd15, 4'd8, 4'd1, 4'd10,
    4'd3, 4'd12,
    4'd6, 4'd11, 4'd3, 4'd7, 4'd0, 4'd13, 4'd5, 4'd10, 4'd14, 4'd15, 4'd8, 4'd12, 4'd4, 4'd9,
    4'd1, 4'd2,
    4'd15, 4'd5, 4'd1, 4'd3, 4'd7, 4'd14, 4'd6, 4'd9, 4'd11, 4'd8, 4'd12, 4'd2, 4'd10, 4'd0,
    4'd4, 4'd13,
    4'd8, 4'd6, 4'd4, 4'd1, 4'd3, 4'd11, 4'd15, 4'd0, 4'd5, 4'd12, 4'd2, 4'd13, 4'd9, 4'd7,
    4'd10, 4'd14,
    4'd12, 4'd15, 4'd10, 4'd4, 4'd1, 4'd5, 4'd8, 4'd7, 4'd6, 4'd2, 4'd13, 4'd14, 4'd0, 4'd3,
    4'd9, 4'd11};
  localparam logic [3:0] SH_L [80] = '{
    4'd11, 4'd14, 4'd15, 4'd12, 4'd5, 4'd8, 4'd7, 4'd9, 4'd11, 4'd13, 4'd14, 4'd15, 4'd6,
    4'd7, 4'd9, 4'd8,
    4'd7, 4'd6, 4'd8, 4'd13, 4'd11, 4'd9, 4'd7, 4'd15, 4'd7, 4'd12, 4'd15, 4'd9, 4'd11,
    4'd7, 4'd13, 4'd12,
    4'd11, 4'd13, 4'd6, 4'd7, 4'd14, 4'd9, 4'd13, 4'd15, 4'd14, 4'd8, 4'd13, 4'd6, 4'd5,
    4'd12, 4'd7, 4'd5,
    4'd11, 4'd12, 4'd14, 4'd15, 4'd14, 4'd15, 4'd9, 4'd8, 4'd9, 4'd14, 4'd5, 4'd6, 4'd8,
    4'd6, 4'd5, 4'd12,
    4'd9, 4'd15, 4'd5, 4'd11, 4'd6, 4'd8, 4'd13, 4'd12, 4'd5, 4'd12, 4'd13, 4'd14, 4'd11,
    4'd8, 4'd5, 4'd6};
  localparam logic [3:0] SH_R [80] = '{
    4'd8, 4'd9, 4'd9, 4'd11, 4'd13, 4'd15, 4'd15, 4'd5, 4'd7, 4'd7, 4'd8, 4'd11, 4'd14,
    4'd14, 4'd12, 4'd6,
    4'd9, 4'd13, 4'd15, 4'd7, 4'd12, 4'd8, 4'd9, 4'd11, 4'd7, 4'd7, 4'd12, 4'd7, 4'd6,
    4'd15, 4'd13, 4'd11,
    4'd9, 4'd7, 4'd15, 4'd11, 4'd8, 4'd6, 4'd6, 4'd14, 4'd12, 4'd13, 4'd5, 4'd14, 4'd13,
    4'd13, 4'd7, 4'd5,
    4'd15, 4'd5, 4'd8, 4'd11, 4'd14, 4'd14, 4'd6, 4'd14, 4'd6, 4'd9, 4'd12, 4'd9, 4'd12,
    4'd5, 4'd15, 4'd8,
    4'd8, 4'd5, 4'd12, 4'd9, 4'd12, 4'd5, 4'd14, 4'd6, 4'd8, 4'd13, 4'd6, 4'd5, 4'd15,
    4'd13, 4'd11, 4'd11};

  localparam logic [31:0] IV_TAB [4][10] = '{
    '{32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'h0, 32'h0, 32'h0, 32'h0,
      32'h0, 32'h0},
    '{32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0, 32'h0, 32'h0,
      32'h0, 32'h0, 32'h0},
    '{32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'h76543210, 32'hFEDCBA98,
      32'h89ABCDEF, 32'h01234567, 32'h0, 32'h0},
    '{32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0, 32'h76543210,
      32'hFEDCBA98, 32'h89ABCDEF, 32'h01234567, 32'h3C2D1E0F}};

  localparam logic [3:0] WORDS [4] = '{4'd4, 4'd5, 4'd8, 4'd10};
  localparam logic [2:0] SWAP320 [5] = '{3'd1, 3'd3, 3'd0, 3'd2, 3'd4};

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] s);
    rotl = (x << s) | (x >> (6'd32 - {1'b0, s}));
  endfunction

  function automatic logic [31:0] boolfn(input logic [2:0] k, input logic [31:0] x,
                                         input logic [31:0] y, input logic [31:0] z);
    case (k)
      3'd0:    boolfn = x ^ y ^ z;
      3'd1:    boolfn = (x & y) | (~x & z);
      3'd2:    boolfn = (x | ~y) ^ z;
      3'd3:    boolfn = (x & z) | (y & ~z);
      default: boolfn = x ^ (y | ~z);
    endcase
  endfunction

endpackage

>>> hdl/rmd_front.sv
// Front end of the RIPEMD engine: input queue that drops items with no work.
// Depends on rmd_pkg.
module rmd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  rmd_pkg::rmd_item_t item,
  output logic              q_valid,
  output rmd_pkg::rmd_item_t q_item,
  input  logic              q_pop
);
  import rmd_pkg::*;

  rmd_item_t  fifo_r [4];
  logic [1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       wr, rd;

  assign full    = (cnt_r == 3'd4);
  // keep only items that carry a byte or end a message
  assign wr      = push && !full && (item.has_byte || item.last);
  assign rd      = q_pop && (cnt_r != 3'd0);
  assign q_valid = (cnt_r != 3'd0);
  assign q_item  = fifo_r[rp_r];

  always_comb begin
    wp_nxt  = wr ? wp_r + 2'd1 : wp_r;
    rp_nxt  = rd ? rp_r + 2'd1 : rp_r;
    cnt_nxt = cnt_r + {2'd0, wr} - {2'd0, rd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) fifo_r[wp_r] <= item;
  end

endmodule

>>> hdl/rmd_core.sv
// Back end of the RIPEMD engine: block buffer, padding, compression and digest output.
// Depends on rmd_pkg.
module rmd_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  rmd_pkg::rmd_item_t q_item,
  output logic               q_pop,
  input  logic [1:0]         variant,
  input  logic               cfg_load,
  input  logic               pop,
  output logic               empty,
  output logic [31:0]        digest_word,
  output logic               word_last
);
  import rmd_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PAD  = 6'b000010,
    S_RD   = 6'b000100,
    S_EX   = 6'b001000,
    S_FIN  = 6'b010000,
    S_EMIT = 6'b100000
  } state_t;

  state_t      st_r, st_nxt;
  logic [31:0] mem [16];
  logic [31:0] xl_r, xr_r;
  logic [31:0] chain_r [10];
  logic [31:0] l_r [5], r_r [5], l_nxt [5], r_nxt [5];
  logic [63:0] cnt_r, bits_r;
  logic [23:0] acc_r;
  logic [6:0]  j_r;
  logic [3:0]  k_r;
  logic        pad_r, pad_first_r, len_done_r, len_blk_r;
  logic        out_v_r;
  logic [31:0] out_w_r;
  logic        out_l_r;

  logic        five, dual;
  logic [2:0]  n;
  logic [2:0]  rd;
  logic [31:0] tl, tr, kr;
  logic [2:0]  sw;
  logic [31:0] swap_t;
  logic        ab_en;
  logic [7:0]  ab_byte;
  logic [5:0]  pos;
  logic [63:0] cnt_inc;
  logic        blk_full;
  logic        slot_free;
  logic        emit_go;
  logic        emit_end;

  assign five = variant[0];
  assign dual = variant[1];
  assign n    = five ? 3'd5 : 3'd4;
  assign rd   = j_r[6:4];
  assign pos  = cnt_r[5:0];
  assign cnt_inc  = cnt_r + 64'd1;
  assign blk_full = (pos == BLK_END);
  assign slot_free = !out_v_r || pop;
  assign emit_go   = (st_r == S_EMIT) && slot_free;
  assign emit_end  = (k_r == WORDS[variant] - 4'd1);

  assign empty       = !out_v_r;
  assign digest_word = out_w_r;
  assign word_last   = out_l_r;
  assign q_pop       = (st_r == S_IDLE) && q_valid;

  // byte to absorb this cycle
  always_comb begin
    ab_en   = 1'b0;
    ab_byte = q_item.data_byte;
    if (st_r == S_IDLE) begin
      ab_en = q_valid && q_item.has_byte;
    end else if (st_r == S_PAD) begin
      ab_en = 1'b1;
      if (pad_first_r) ab_byte = PAD_BYTE;
      else if (!len_blk_r || pos < LEN_POS) ab_byte = 8'h00;
      else ab_byte = bits_r[{pos[2:0], 3'b000} +: 8];
    end
  end

  // one round of both lines
  always_comb begin
    swap_t = '0;
    kr = five ? KR5[rd] : KR4[rd];
    tl = rotl(l_r[0] + boolfn(rd, l_r[1], l_r[2], l_r[3]) + xl_r + KL[rd],
              {1'b0, SH_L[j_r]}) + (five ? l_r[4] : 32'd0);
    tr = rotl(r_r[0] + boolfn(n - 3'd1 - rd, r_r[1], r_r[2], r_r[3]) + xr_r + kr,
              {1'b0, SH_R[j_r]}) + (five ? r_r[4] : 32'd0);
    if (five) begin
      l_nxt[0] = l_r[4]; l_nxt[4] = l_r[3]; l_nxt[3] = rotl(l_r[2], 5'd10);
      l_nxt[2] = l_r[1]; l_nxt[1] = tl;
      r_nxt[0] = r_r[4]; r_nxt[4] = r_r[3]; r_nxt[3] = rotl(r_r[2], 5'd10);
      r_nxt[2] = r_r[1]; r_nxt[1] = tr;
    end else begin
      l_nxt[0] = l_r[3]; l_nxt[3] = l_r[2]; l_nxt[2] = l_r[1]; l_nxt[1] = tl;
      l_nxt[4] = l_r[4];
      r_nxt[0] = r_r[3]; r_nxt[3] = r_r[2]; r_nxt[2] = r_r[1]; r_nxt[1] = tr;
      r_nxt[4] = r_r[4];
    end
    sw = five ? SWAP320[rd] : rd;
    // in the 256 and 320 variants, swap one word between the lines at the end of each group of 16
    if (dual && (j_r[3:0] == 4'hF)) begin
      for (int i = 0; i < 5; i++) begin
        if (sw == 3'(i)) begin
          swap_t   = l_nxt[i];
          l_nxt[i] = r_nxt[i];
          r_nxt[i] = swap_t;
        end
      end
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: begin
        if (q_valid) begin
          if (q_item.has_byte && blk_full) st_nxt = S_RD;
          else if (q_item.last) st_nxt = S_PAD;
        end
      end
      S_PAD:  st_nxt = blk_full ? S_RD : S_PAD;
      S_RD:   st_nxt = S_EX;
      S_EX:   st_nxt = (j_r == {n - 3'd1, 4'hF}) ? S_FIN : S_RD;
      S_FIN:  st_nxt = !pad_r ? S_IDLE : (len_done_r ? S_EMIT : S_PAD);
      S_EMIT: st_nxt = (slot_free && emit_end) ? S_IDLE : S_EMIT;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      cnt_r       <= '0;
      pad_r       <= 1'b0;
      pad_first_r <= 1'b0;
      len_done_r  <= 1'b0;
      len_blk_r   <= 1'b0;
      out_v_r     <= 1'b0;
      k_r         <= '0;
      j_r         <= '0;
      for (int i = 0; i < 10; i++) chain_r[i] <= IV_TAB[VAR_160][i];
    end else if (cfg_load) begin
      // drop the message in progress
      st_r        <= S_IDLE;
      cnt_r       <= '0;
      pad_r       <= 1'b0;
      pad_first_r <= 1'b0;
      len_done_r  <= 1'b0;
      len_blk_r   <= 1'b0;
      k_r         <= '0;
      for (int i = 0; i < 10; i++) chain_r[i] <= IV_TAB[variant][i];
    end else begin
      st_r <= st_nxt;
      if (pop && !emit_go) out_v_r <= 1'b0;
      if (ab_en) begin
        cnt_r <= cnt_inc;
        if (st_r == S_PAD) begin
          pad_first_r <= 1'b0;
          // length goes in the block after a pad byte that lands too late
          if (pos == BLK_END) begin
            len_done_r <= len_blk_r;
            len_blk_r  <= 1'b1;
          end
        end
      end
      if ((st_r == S_IDLE) && q_valid && q_item.last) begin
        pad_r       <= 1'b1;
        pad_first_r <= 1'b1;
        len_done_r  <= 1'b0;
        len_blk_r   <= ((q_item.has_byte ? cnt_inc[5:0] : pos) < LEN_POS);
        bits_r      <= {(q_item.has_byte ? cnt_inc[60:0] : cnt_r[60:0]), 3'b000};
      end
      if (ab_en && blk_full) begin
        j_r <= '0;
        for (int i = 0; i < 5; i++) begin
          l_r[i] <= (i < n) ? chain_r[i] : 32'd0;
          r_r[i] <= (i < n) ? chain_r[dual ? n + i : i] : 32'd0;
        end
      end
      if (st_r == S_EX) begin
        j_r <= j_r + 7'd1;
        for (int i = 0; i < 5; i++) begin
          l_r[i] <= l_nxt[i];
          r_r[i] <= r_nxt[i];
        end
      end
      if (st_r == S_FIN) begin
        if (dual) begin
          for (int i = 0; i < 5; i++) begin
            if (i < n) begin
              chain_r[i]     <= chain_r[i] + l_r[i];
              chain_r[n + i] <= chain_r[n + i] + r_r[i];
            end
          end
        end else if (five) begin
          chain_r[0] <= chain_r[1] + l_r[2] + r_r[3];
          chain_r[1] <= chain_r[2] + l_r[3] + r_r[4];
          chain_r[2] <= chain_r[3] + l_r[4] + r_r[0];
          chain_r[3] <= chain_r[4] + l_r[0] + r_r[1];
          chain_r[4] <= chain_r[0] + l_r[1] + r_r[2];
        end else begin
          chain_r[0] <= chain_r[1] + l_r[2] + r_r[3];
          chain_r[1] <= chain_r[2] + l_r[3] + r_r[0];
          chain_r[2] <= chain_r[3] + l_r[0] + r_r[1];
          chain_r[3] <= chain_r[0] + l_r[1] + r_r[2];
        end
      end
      if (emit_go) begin
        out_v_r <= 1'b1;
        out_w_r <= chain_r[k_r];
        out_l_r <= emit_end;
        k_r     <= emit_end ? '0 : k_r + 4'd1;
        if (emit_end) begin
          // reload the initial vector for the next message
          cnt_r  <= '0;
          pad_r  <= 1'b0;
          len_done_r <= 1'b0;
          for (int i = 0; i < 10; i++) chain_r[i] <= IV_TAB[variant][i];
        end
      end
    end
  end

  // byte packing and word buffer
  always_ff @(posedge clk) begin
    if (ab_en) begin
      acc_r <= {ab_byte, acc_r[23:8]};
      if (pos[1:0] == 2'd3) mem[pos[5:2]] <= {ab_byte, acc_r};
    end
    if (st_r == S_RD) begin
      xl_r <= mem[MSG_L[j_r]];
      xr_r <= mem[MSG_R[j_r]];
    end
  end

endmodule

>>> hdl/ripemd_hash_engine_core.sv
// Top level of the RIPEMD hash engine: configuration register, front queue, core.
// Depends on rmd_pkg, rmd_front and rmd_core.
//
//  channel   ports                                   handshake
//  input     in_data_byte, in_has_byte, in_last       push / full
//  result    out_digest_word, out_word_last           pop / empty
//  config    psel penable pwrite paddr pwdata prdata  APB, pready tied high
//
// The core absorbs bytes while idle; a full block then runs its rounds, each a
// buffer read then round logic, and the chaining add. Finishing pads one byte
// per cycle except while a block compresses, 9 to 72 bytes over one or two
// blocks, then emits one word per cycle while the result side keeps up.
// Reset is synchronous; the queue of four items absorbs stalls on the input,
// a single output register holds a word until it is popped.
module ripemd_hash_engine_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_last,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] out_digest_word,
  output logic        out_word_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rmd_pkg::*;

  rmd_item_t  item, q_item;
  logic       q_valid, q_pop;
  logic [1:0] variant_r;
  logic       cfg_load;

  assign pready   = 1'b1;
  assign cfg_load = psel && penable && pwrite && (paddr == 2'd0);
  assign prdata   = (paddr == 2'd0) ? {30'd0, variant_r} : 32'd0;
  assign item     = '{data_byte: in_data_byte, has_byte: in_has_byte, last: in_last};

  always_ff @(posedge clk) begin
    if (!rst_n) variant_r <= VAR_160;
    else if (cfg_load) variant_r <= pwdata[1:0];
  end

  rmd_front u_front (
    .clk, .rst_n, .push, .full, .item,
    .q_valid, .q_item, .q_pop
  );

  rmd_core u_core (
    .clk, .rst_n, .q_valid, .q_item, .q_pop,
    .variant (cfg_load ? pwdata[1:0] : variant_r),
    .cfg_load, .pop, .empty,
    .digest_word (out_digest_word),
    .word_last   (out_word_last)
  );

endmodule

>>> hdl/rmd_checker.sv
// Port-level checks for the RIPEMD hash engine, bound to the top level.
// Depends on ripemd_hash_engine_core only through the bind below.
module rmd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [31:0] out_digest_word,
  input logic        out_word_last
);
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");
  a_rst_full: assert property (@(posedge clk) !rst_n |=> !full)
    else $error("input queue full after reset");
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !empty && out_word_last) |=> empty)
    else $error("word follows final digest word at once");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_digest_word)))
    else $error("waiting result changed");
endmodule

bind ripemd_hash_engine_core rmd_checker u_chk (
  .clk, .rst_n, .full, .empty, .pop, .out_digest_word, .out_word_last
);
